### rtl/dual_wiper_pot_angle_tracker_defines.svh
// Assertion macros for the dual-wiper potentiometer angle tracker.
`ifndef DUAL_WIPER_POT_ANGLE_TRACKER_DEFINES_SVH
`define DUAL_WIPER_POT_ANGLE_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DWPAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DWPAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dwpat_pkg.sv
// Shared types and constants of the dual-wiper potentiometer angle tracker.
`timescale 1ns / 1ps
`default_nettype none
package dwpat_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int FRAC_BITS    = 24;
  localparam int K_W          = 30;
  localparam logic [K_W-1:0] K_Q16 = 30'd683565276;
  localparam int DIV_CNT_W    = $clog2(FRAC_BITS);
  localparam int TERM_W       = FRAC_BITS + K_W - 16;
  localparam int V_W          = FRAC_BITS + 18;

  localparam logic signed [V_W-1:0] V_HALF = V_W'(64'd32768 << FRAC_BITS);
  localparam logic signed [V_W-1:0] V_QTR  = V_W'(64'd16384 << FRAC_BITS);

  localparam logic [15:0] HYST_RST = 16'd64;
  localparam logic        REG_HYST = 1'b0;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;
  localparam logic [1:0] CONF_MAX = 2'd2;

  typedef enum logic [3:0] {
    ANG_IDLE,
    ANG_MUL_XY,
    ANG_MUL_BB,
    ANG_MUL_SS,
    ANG_SCALE,
    ANG_DEN,
    ANG_DIV,
    ANG_MUL_K,
    ANG_SUM,
    ANG_TRUNC,
    ANG_SAT,
    ANG_DONE
  } ang_state_e;

  typedef struct packed {
    logic start;
    logic ack;
  } ang_cmd_t;

  typedef struct packed {
    logic               ready;
    logic               done;
    logic signed [15:0] angle;
  } ang_stat_t;

endpackage
`default_nettype wire

### rtl/dwpat_angle.sv
// Sequenced fast-atan2 angle unit: shared multiplier and restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module dwpat_angle
  import dwpat_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ang_cmd_t            cmd_i,
  input  logic [ADC_BITS-1:0] sample_a_i,
  input  logic [ADC_BITS-1:0] sample_b_i,
  output ang_stat_t           stat_o
);

  localparam int PW    = 2 * ADC_BITS;
  localparam int NUM_W = PW + 7;
  localparam int MA_W  = FRAC_BITS;
  localparam int MB_W  = K_W;
  localparam int CW    = ADC_BITS + 2;

  ang_state_e state_q, state_d;

  logic [ADC_BITS-1:0]  ax_q, ay_q;
  logic                 xneg_q, yneg_q, ratio_q;
  logic [PW-1:0]        p_xy_q, p_bb_q, p_ss_q;
  logic [NUM_W-1:0]     rem_q, den_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TERM_W-1:0]    term_q;
  logic signed [V_W-1:0] v_q;
  logic                 vneg_q;
  logic [17:0]          ip_q;
  logic signed [15:0]   angle_q;

  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [MA_W+MB_W-1:0] prod;

  logic [CW-1:0]        xs, ys;
  logic [ADC_BITS-1:0]  big, small_v;
  logic [NUM_W-1:0]     xy_ext, bb_ext, ss_ext;
  logic [NUM_W:0]       rem_sh, rem_sub;
  logic                 neg, add_term;
  logic signed [V_W-1:0] base, tx, v_mag;
  logic                 div_last;

  // centering: 2*adc - (2^N - 1)
  assign xs = {1'b0, sample_a_i, 1'b0} - CW'({ADC_BITS{1'b1}});
  assign ys = {1'b0, sample_b_i, 1'b0} - CW'({ADC_BITS{1'b1}});

  assign big     = ratio_q ? ax_q : ay_q;
  assign small_v = ratio_q ? ay_q : ax_q;
  assign prod    = mul_a * mul_b;

  assign xy_ext = NUM_W'(p_xy_q);
  assign bb_ext = NUM_W'(p_bb_q);
  assign ss_ext = NUM_W'(p_ss_q);

  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign neg      = xneg_q ^ yneg_q;
  assign add_term = ratio_q ? !neg : neg;
  assign tx       = V_W'(term_q);
  assign v_mag    = v_q[V_W-1] ? -v_q : v_q;
  assign div_last = (cnt_q == DIV_CNT_W'(FRAC_BITS - 1));

  always_comb begin
    if (ratio_q) begin
      if (xneg_q) begin
        base = yneg_q ? -V_HALF : V_HALF;
      end else begin
        base = '0;
      end
    end else begin
      base = yneg_q ? (V_QTR - V_HALF) : V_QTR;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ANG_IDLE:   if (cmd_i.start) state_d = ANG_MUL_XY;
      ANG_MUL_XY: state_d = ANG_MUL_BB;
      ANG_MUL_BB: state_d = ANG_MUL_SS;
      ANG_MUL_SS: state_d = ANG_SCALE;
      ANG_SCALE:  state_d = ANG_DEN;
      ANG_DEN:    state_d = ANG_DIV;
      ANG_DIV:    if (div_last) state_d = ANG_MUL_K;
      ANG_MUL_K:  state_d = ANG_SUM;
      ANG_SUM:    state_d = ANG_TRUNC;
      ANG_TRUNC:  state_d = ANG_SAT;
      ANG_SAT:    state_d = ANG_DONE;
      ANG_DONE:   if (cmd_i.ack) state_d = ANG_IDLE;
      default:    state_d = ANG_IDLE;
    endcase
  end

  always_comb begin
    mul_a        = MA_W'(ax_q);
    mul_b        = MB_W'(ay_q);
    stat_o.ready = 1'b0;
    stat_o.done  = 1'b0;
    stat_o.angle = angle_q;
    case (state_q)
      ANG_IDLE: stat_o.ready = 1'b1;
      ANG_MUL_BB: begin
        mul_a = MA_W'(big);
        mul_b = MB_W'(big);
      end
      ANG_MUL_SS: begin
        mul_a = MA_W'(small_v);
        mul_b = MB_W'(small_v);
      end
      ANG_MUL_K: begin
        mul_a = quo_q;
        mul_b = K_Q16;
      end
      ANG_DONE: stat_o.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ANG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ANG_IDLE: begin
        if (cmd_i.start) begin
          xneg_q <= xs[CW-1];
          yneg_q <= ys[CW-1];
          ax_q   <= xs[CW-1] ? ADC_BITS'(-xs) : ADC_BITS'(xs);
          ay_q   <= ys[CW-1] ? ADC_BITS'(-ys) : ADC_BITS'(ys);
        end
      end
      ANG_MUL_XY: begin
        p_xy_q  <= prod[PW-1:0];
        ratio_q <= (ay_q < ax_q);
      end
      ANG_MUL_BB: p_bb_q <= prod[PW-1:0];
      ANG_MUL_SS: p_ss_q <= prod[PW-1:0];
      ANG_SCALE: begin
        rem_q <= (xy_ext << 6) + (xy_ext << 5) + (xy_ext << 2);
        den_q <= (bb_ext << 6) + (bb_ext << 5) + (bb_ext << 2);
      end
      ANG_DEN: begin
        den_q <= den_q + (ss_ext << 4) + (ss_ext << 3) + (ss_ext << 2);
        quo_q <= '0;
        cnt_q <= '0;
      end
      ANG_DIV: begin
        cnt_q <= cnt_q + 1'b1;
        if (!rem_sub[NUM_W]) begin
          rem_q <= rem_sub[NUM_W-1:0];
          quo_q <= {quo_q[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[NUM_W-1:0];
          quo_q <= {quo_q[FRAC_BITS-2:0], 1'b0};
        end
      end
      ANG_MUL_K: term_q <= prod[MA_W+MB_W-1:16];
      ANG_SUM: begin
        v_q    <= add_term ? (base + tx) : (base - tx);
      end
      ANG_TRUNC: begin
        vneg_q <= v_q[V_W-1];
        ip_q   <= 18'(v_mag >>> FRAC_BITS);
      end
      ANG_SAT: begin
        if (vneg_q) begin
          angle_q <= (ip_q > 18'd32768) ? -16'sd32768 : -$signed(ip_q[15:0]);
        end else begin
          angle_q <= (ip_q > 18'd32767) ? 16'sd32767 : $signed(ip_q[15:0]);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/dual_wiper_pot_angle_tracker.sv
// Top level of the dual-wiper potentiometer angle tracker.
//
// Each input word carries one pair of wiper readings and yields one output
// word: the direction of accepted movement (0 none, 1 up, 2 down) and the
// held angle in pi/32768 units. The angle comes from a rational atan2
// computed on one shared multiplier plus a 24-step restoring divider.
// s_axis_tready is low from acceptance until the result is loaded into the
// output register, so only one word is in flight, and it stays low while a
// full output register holds the finished result back. A finished result
// sits in an output register, and the next sample is accepted while it
// waits. The movement threshold (hysteresis, reset 64) is at APB address 0x0.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_wiper_pot_angle_tracker_defines.svh"
module dual_wiper_pot_angle_tracker
  import dwpat_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_a, sample_b
  input  logic [((2*ADC_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // direction[1:0], held_angle[17:2]
  output logic [23:0]                          m_axis_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  ang_cmd_t  ang_cmd;
  ang_stat_t ang_stat;

  logic [15:0]        hyst_q;
  logic signed [15:0] stored_q, stored_d;
  logic [1:0]         conf_q, conf_d, conf_inc;
  logic               m_valid_q;
  logic [1:0]         m_dir_q, dir_d;
  logic signed [15:0] m_angle_q;
  logic               out_free, res_load, cfg_wr;
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic               move;

  assign s_axis_tready = ang_stat.ready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign res_load      = ang_stat.done && out_free;
  assign ang_cmd.start = s_axis_tvalid && s_axis_tready;
  assign ang_cmd.ack   = res_load;

  dwpat_angle #(
    .ADC_BITS (ADC_BITS)
  ) u_angle (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ang_cmd),
    .sample_a_i (s_axis_tdata[ADC_BITS-1:0]),
    .sample_b_i (s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
    .stat_o     (ang_stat)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HYST);
  assign prdata = (paddr[2] == REG_HYST) ? {16'd0, hyst_q} : 32'd0;

  assign diff     = {ang_stat.angle[15], ang_stat.angle} - {stored_q[15], stored_q};
  assign mag      = diff[16] ? 17'(-diff) : 17'(diff);
  assign move     = mag > {1'b0, hyst_q};
  assign conf_inc = (conf_q == CONF_MAX) ? CONF_MAX : conf_q + 2'd1;

  always_comb begin
    stored_d = stored_q;
    conf_d   = conf_q;
    dir_d    = DIR_NONE;
    if (move) begin
      conf_d = conf_inc;
      if (conf_inc == CONF_MAX) begin
        stored_d = ang_stat.angle;
        dir_d    = diff[16] ? DIR_DOWN : DIR_UP;
      end
    end else begin
      conf_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q    <= HYST_RST;
      stored_q  <= '0;
      conf_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        hyst_q <= pwdata[15:0];
      end
      if (res_load) begin
        stored_q  <= stored_d;
        conf_q    <= conf_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      m_dir_q   <= dir_d;
      m_angle_q <= stored_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_angle_q, m_dir_q};

  `DWPAT_ASSERT_NEXT(a_one_word_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word accepted while busy")
  `DWPAT_ASSERT_NEXT(a_result_waits, ang_stat.done && !out_free, ang_stat.done, "finished angle dropped before output slot freed")
  `DWPAT_ASSERT_SAME(a_move_changes_angle, res_load && (dir_d != DIR_NONE), stored_d != stored_q, "movement reported without angle change")
  `DWPAT_ASSERT_SAME(a_dir_code, m_axis_tvalid, (m_dir_q == DIR_NONE) || (m_dir_q == DIR_UP) || (m_dir_q == DIR_DOWN), "bad direction code")

endmodule
`default_nettype wire

### sim/dual_wiper_pot_angle_tracker_test.sv
// Self-checking testbench of the dual-wiper potentiometer angle tracker.
`timescale 1ns / 1ps
module dual_wiper_pot_angle_tracker_test;
  import dwpat_pkg::*;

  localparam int TDATA_W       = ((2 * ADC_BITS_DEF + 7) / 8) * 8;
  localparam longint ADC_FULL  = (longint'(1) << ADC_BITS_DEF) - 1;
  localparam int STALL_LIMIT   = 4000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int END_CYCLES    = 60;

  typedef struct {
    logic [1:0]         dir;
    logic signed [15:0] angle;
  } track_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // sample_a[11:0], sample_b[23:12]
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // direction[1:0], held_angle[17:2]
  logic [23:0]        m_axis_tdata;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // tracker state as predicted
  logic [15:0]        hyst_cfg = HYST_RST;
  logic signed [15:0] held_angle_q = '0;
  logic [1:0]         conf_q = '0;
  logic [1:0]         dir_q = DIR_NONE;

  logic [TDATA_W-1:0] pair_q[$];
  track_result_t      result_q[$];
  track_result_t      want;
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  int                 tx_idle_pct = 0;
  int                 rx_stall_pct = 0;
  logic               rx_hold = 1'b0;

  real                sweep_theta = 0.0;
  real                sweep_radius = 1000.0;
  real                sweep_step = 0.1;
  int                 sweep_left = 0;

  dual_wiper_pot_angle_tracker #(
    .ADC_BITS(ADC_BITS_DEF)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // fast atan2, pi/32768 units, truncated toward zero and saturated
  function automatic logic signed [15:0] wiper_angle(logic [11:0] a, logic [11:0] b);
    longint x, y, ax, ay, num, den, rem, q, term, v, one;
    bit ratio;
    x = 2 * (longint'(a) & ADC_FULL) - ADC_FULL;
    y = 2 * (longint'(b) & ADC_FULL) - ADC_FULL;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    one = longint'(1) << FRAC_BITS;
    ratio = ay < ax;
    num = 100 * ax * ay;
    den = ratio ? (100 * ax * ax + 28 * ay * ay) : (100 * ay * ay + 28 * ax * ax);
    if (num >= den) num = den - 1;
    rem = num;
    q = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    term = (q * longint'(K_Q16)) >>> 16;
    if ((x < 0) != (y < 0)) term = -term;
    if (ratio) begin
      v = term;
      if (x < 0) v = (y < 0) ? v - 32768 * one : v + 32768 * one;
    end else begin
      v = 16384 * one - term;
      if (y < 0) v = v - 32768 * one;
    end
    if (v >= 0) v = v >>> FRAC_BITS;
    else v = -((-v) >>> FRAC_BITS);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic track_result_t track_step(logic [TDATA_W-1:0] word);
    track_result_t res;
    logic signed [15:0] cur;
    int diff, mag;
    cur = wiper_angle(word[11:0], word[23:12]);
    diff = int'(cur) - int'(held_angle_q);
    mag = (diff < 0) ? -diff : diff;
    res.dir = DIR_NONE;
    if (mag > int'(hyst_cfg)) begin
      if (conf_q < CONF_MAX) conf_q = conf_q + 2'd1;
      if (conf_q >= CONF_MAX) begin
        held_angle_q = cur;
        dir_q = (diff > 0) ? DIR_UP : DIR_DOWN;
        res.dir = dir_q;
      end
    end else begin
      conf_q = '0;
      dir_q = DIR_NONE;
    end
    res.angle = held_angle_q;
    return res;
  endfunction

  // mostly rotation sweeps, some random pairs and rail values
  function automatic logic [TDATA_W-1:0] next_pair();
    int pick, a, b;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      if (sweep_left == 0) begin
        sweep_left = $urandom_range(3, 20);
        sweep_radius = real'($urandom_range(40, 2047));
        sweep_step = (real'($urandom_range(0, 4000)) - 2000.0) / 5000.0;
        sweep_theta = real'($urandom_range(0, 6283)) / 1000.0;
      end
      sweep_left--;
      sweep_theta = sweep_theta + sweep_step;
      a = int'(2047.5 + sweep_radius * $cos(sweep_theta));
      b = int'(2047.5 + sweep_radius * $sin(sweep_theta));
    end else if (pick < 90) begin
      a = $urandom_range(0, 4095);
      b = $urandom_range(0, 4095);
    end else begin
      a = ($urandom_range(0, 1) != 0) ? 4095 : 0;
      b = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) :
          (($urandom_range(0, 1) != 0) ? 4095 : 0);
    end
    if (a < 0) a = 0;
    if (a > 4095) a = 4095;
    if (b < 0) b = 0;
    if (b > 4095) b = 4095;
    return TDATA_W'({12'(b), 12'(a)});
  endfunction

  task automatic push_pair(input int a, input int b);
    pair_q.push_back(TDATA_W'({12'(b), 12'(a)}));
  endtask

  task automatic hyst_write(input logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(REG_HYST) << 2;
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    hyst_cfg = value;
  endtask

  task automatic wait_drained();
    while (pair_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) pair_q.push_back(next_pair());
    wait_drained();
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // input driver, predicts each word as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) result_q.push_back(track_step(s_axis_tdata));
      if (pair_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tdata <= pair_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word %h", $time, m_axis_tdata);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[1:0] !== want.dir) begin
            mismatch_count++;
            $display("%0t: direction expected %0d actual %0d", $time, want.dir,
                     m_axis_tdata[1:0]);
          end
          if ($signed(m_axis_tdata[17:2]) !== want.angle) begin
            mismatch_count++;
            $display("%0t: held_angle expected %0d actual %0d", $time, want.angle,
                     $signed(m_axis_tdata[17:2]));
          end
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // corners, quadrants, confidence build-up and clear, reset threshold
    @(negedge clk_i);
    push_pair(4095, 2048);
    push_pair(2048, 4095);
    push_pair(2048, 4095);
    push_pair(0, 2048);
    push_pair(0, 2047);
    push_pair(0, 2047);
    push_pair(2047, 0);
    push_pair(4095, 4095);
    push_pair(0, 0);
    push_pair(0, 4095);
    push_pair(4095, 0);
    push_pair(2047, 2048);
    push_pair(2048, 2047);
    push_pair(2047, 2047);
    push_pair(2048, 2048);
    push_pair(4095, 2047);
    push_pair(2048, 0);
    push_pair(1000, 4095);
    push_pair(4095, 3000);
    wait_drained();

    hyst_write(16'd0);
    run_phase(130, 0, 0);
    hyst_write(16'hFFFF);
    run_phase(60, 53, 0);
    hyst_write(16'($urandom_range(1, 1000)));
    run_phase(130, 0, 53);

    // back-pressure: receiver held off while words keep coming, then a sender pause
    hyst_write(16'd300);
    @(negedge clk_i);
    tx_idle_pct = 13;
    rx_stall_pct = 13;
    fork
      begin
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    repeat (65) pair_q.push_back(next_pair());
    wait_drained();
    repeat (65) pair_q.push_back(next_pair());
    wait_drained();

    hyst_write(16'($urandom_range(16, 4000)));
    run_phase(100, 0, 0);

    repeat (END_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/dwpat_pkg.sv
rtl/dwpat_angle.sv
rtl/dual_wiper_pot_angle_tracker.sv
sim/dual_wiper_pot_angle_tracker_test.sv
